[hdl/aae_pkg.sv]
// shared constants, codes and controller/datapath structs for the adaptive arithmetic encoder
// no dependencies
`default_nettype none

package aae_pkg;

    localparam int SYMBOLS_DEF    = 256;
    localparam int STATE_BITS_DEF = 32;
    localparam int SYM_W          = 8;
    localparam int CNT_W          = 31;
    localparam int PEND_W         = 32;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic load;
        logic sum_run;
        logic ar_start;
        logic ar_sel;
        logic upd;
        logic ren_start;
        logic ren1_step;
        logic ren2_step;
        logic emit_mark;
        logic emit_flush;
        logic clear_model;
    } ctl_cmd_t;

    typedef struct packed {
        logic op_flush;
        logic sum_done;
        logic ar_done;
        logic ren1_go;
        logic ren2_go;
        logic out_free;
        logic mark;
        logic coded;
    } dp_status_t;

endpackage

`default_nettype wire

[hdl/aae_if.sv]
// valid/ready channel interfaces for symbols in and bit runs out
// depends on aae_pkg
`default_nettype none

interface aae_in_if import aae_pkg::*;;
    logic             valid;
    logic             ready;
    logic             op;
    logic [SYM_W-1:0] symbol;

    modport source (output valid, op, symbol, input ready);
    modport sink (input valid, op, symbol, output ready);
endinterface

interface aae_out_if import aae_pkg::*;;
    logic              valid;
    logic              ready;
    logic              lead_bit;
    logic [PEND_W-1:0] run_length;
    logic              last;

    modport source (output valid, lead_bit, run_length, last, input ready);
    modport sink (input valid, lead_bit, run_length, last, output ready);
endinterface

`default_nettype wire

[hdl/adaptive_arith_encoder.sv]
// top level of the adaptive order-0 arithmetic encoder
// depends on aae_pkg, aae_if, aae_ctrl, aae_datapath
`default_nettype none

// Adaptive order-0 arithmetic encoder over byte symbols. Each input transaction
// is either an encode (op 0, symbol) or a flush (op 1). An encode produces zero
// or more output transactions, each a lead bit followed by run_length inverted
// copies; last marks the final one for that input. When the symbol total passes
// 2^(STATE_BITS-2)+2 a marker transaction (lead 1, run 0) is added and the model
// returns to its reset state. A flush gives one transaction (1, 0) if any symbol
// was coded since the last model reset, otherwise none. Symbols at or above
// SYMBOLS are coded as SYMBOLS-1. One item is worked at a time; input ready is
// high only between items, while a finished result may still wait in the output
// register. An encode runs the accept and the serial prefix sum over the single
// read port of the count memory, then the bit-serial multiply/divide unit once
// for each bound of the interval, then renormalization with at most 2*STATE_BITS
// emitted or underflow bits, plus any output stall. Counts come out of reset all
// ones through per-entry valid bits, so there is no clearing pass.
module adaptive_arith_encoder import aae_pkg::*;
#(
    parameter int SYMBOLS    = SYMBOLS_DEF,
    parameter int STATE_BITS = STATE_BITS_DEF
)
(
    input wire logic clk,
    input wire logic rst_n,
    aae_in_if.sink   in_ch,
    aae_out_if.source out_ch
);

    // command and status bundle between sequencer and datapath
    ctl_cmd_t   cmd;
    dp_status_t sts;

    aae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    aae_datapath #(
        .SYMBOLS    (SYMBOLS),
        .STATE_BITS (STATE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_op          (in_ch.op),
        .in_symbol      (in_ch.symbol),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_lead_bit   (out_ch.lead_bit),
        .out_run_length (out_ch.run_length),
        .out_last       (out_ch.last),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

`default_nettype wire

[hdl/aae_ctrl.sv]
// sequencing state machine for the encoder
// depends on aae_pkg
`default_nettype none

module aae_ctrl import aae_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t sts,
    output ctl_cmd_t        cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SUM    = 4'd1;
    localparam logic [3:0] S_AR1_GO = 4'd2;
    localparam logic [3:0] S_AR1    = 4'd3;
    localparam logic [3:0] S_AR2_GO = 4'd4;
    localparam logic [3:0] S_AR2    = 4'd5;
    localparam logic [3:0] S_UPD    = 4'd6;
    localparam logic [3:0] S_REN1   = 4'd7;
    localparam logic [3:0] S_REN2   = 4'd8;
    localparam logic [3:0] S_MARK   = 4'd9;
    localparam logic [3:0] S_FLUSH  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.op_flush ? S_FLUSH : S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_run = 1'b1;
                if (sts.sum_done)
                    state_next = S_AR1_GO;
            end
            S_AR1_GO:
            begin
                cmd.ar_start = 1'b1;
                state_next   = S_AR1;
            end
            S_AR1:
            begin
                if (sts.ar_done)
                    state_next = S_AR2_GO;
            end
            S_AR2_GO:
            begin
                cmd.ar_start = 1'b1;
                cmd.ar_sel   = 1'b1;
                state_next   = S_AR2;
            end
            S_AR2:
            begin
                if (sts.ar_done)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd       = 1'b1;
                cmd.ren_start = 1'b1;
                state_next    = S_REN1;
            end
            S_REN1:
            begin
                if (sts.ren1_go)
                begin
                    cmd.ren1_step = sts.out_free;
                end
                else
                begin
                    cmd.ren_start = 1'b1;
                    state_next    = S_REN2;
                end
            end
            S_REN2:
            begin
                if (sts.ren2_go)
                    cmd.ren2_step = 1'b1;
                else
                    state_next = S_MARK;
            end
            S_MARK:
            begin
                if (!sts.mark)
                    state_next = S_IDLE;
                else if (sts.out_free)
                begin
                    cmd.emit_mark   = 1'b1;
                    cmd.clear_model = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (!sts.coded)
                    state_next = S_IDLE;
                else if (sts.out_free)
                begin
                    cmd.emit_flush = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[hdl/aae_datapath.sv]
// count memory, prefix sum, bit-serial multiply/divide, interval registers and output register
// depends on aae_pkg
`default_nettype none

module aae_datapath import aae_pkg::*;
#(
    parameter int SYMBOLS    = SYMBOLS_DEF,
    parameter int STATE_BITS = STATE_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_op,
    input  wire logic [SYM_W-1:0]  in_symbol,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_lead_bit,
    output logic [PEND_W-1:0]      out_run_length,
    output logic                   out_last,
    input  wire ctl_cmd_t          cmd,
    output dp_status_t             sts
);

    localparam int SB  = STATE_BITS;
    localparam int IW  = $clog2(SYMBOLS);
    localparam int CW  = CNT_W;
    localparam int RW  = SB + 1;
    localparam int PW  = CW + RW;
    localparam int SCW = $clog2(RW + PW + 1);
    localparam int IBW = $clog2(SB + 1);

    localparam logic [CW-1:0]  TOTAL_RST = CW'(SYMBOLS);
    localparam logic [CW-1:0]  LIMIT     = CW'((64'd1 << (SB - 2)) + 64'd2);
    localparam logic [IBW-1:0] SB_CNT    = IBW'(SB);

    // count store, valid bits give the all-ones reset
    logic [CW-1:0]      mem [SYMBOLS];
    logic [SYMBOLS-1:0] vbits_reg;

    logic [IW-1:0]     sym_reg;
    logic [IW:0]       idx_reg;
    logic              rd_live_reg;
    logic              rd_tag_reg;
    logic [CW-1:0]     rd_data_reg;
    logic              rd_vld_reg;
    logic [CW-1:0]     cum_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     a_reg;
    logic [RW-1:0]     rng_reg;
    logic [PW-1:0]     acc_reg;
    logic [CW-1:0]     rem_reg;
    logic [RW-1:0]     q_reg;
    logic [SCW-1:0]    step_reg;
    logic              busy_reg;
    logic [SB-1:0]     nlow_reg;
    logic [SB-1:0]     low_reg;
    logic [SB-1:0]     high_reg;
    logic [PEND_W-1:0] pend_reg;
    logic [CW-1:0]     total_reg;
    logic [IBW-1:0]    i_reg;
    logic              out_valid_reg;
    logic              out_lead_reg;
    logic [PEND_W-1:0] out_run_reg;
    logic              out_last_reg;

    logic [IW-1:0] sym_sat;
    logic          issue;
    logic [CW-1:0] rd_val;
    logic [RW-1:0] range_w;
    logic [CW:0]   rem_sh;
    logic [CW:0]   rem_sub;
    logic          div_ge;
    logic          ren1_go;
    logic          ren2_go;
    logic          mark;
    logic          ren1_last;
    logic          out_free;
    logic          emit_any;

    assign sym_sat = ({1'b0, in_symbol} >= (SYM_W + 1)'(SYMBOLS))
                   ? IW'(SYMBOLS - 1) : in_symbol[IW-1:0];
    assign issue   = cmd.sum_run && (idx_reg <= {1'b0, sym_reg});
    assign rd_val  = rd_vld_reg ? rd_data_reg : CW'(1);
    assign range_w = {1'b0, high_reg} - {1'b0, low_reg} + RW'(1);
    assign rem_sh  = {rem_reg, acc_reg[PW-1]};
    assign div_ge  = rem_sh >= {1'b0, total_reg};
    assign rem_sub = rem_sh - {1'b0, total_reg};
    assign ren1_go = (low_reg[SB-1] == high_reg[SB-1]) && (i_reg < SB_CNT);
    assign ren2_go = low_reg[SB-2] && !high_reg[SB-2] && (i_reg < SB_CNT);
    assign mark    = total_reg > LIMIT;
    // last run of this symbol if the next shift breaks the match and no marker follows
    assign ren1_last = !((low_reg[SB-2] == high_reg[SB-2]) && ((i_reg + IBW'(1)) < SB_CNT))
                     && !mark;
    assign out_free = !out_valid_reg || out_ready;
    assign emit_any = cmd.ren1_step || cmd.emit_mark || cmd.emit_flush;

    assign sts.op_flush = (in_op == OP_FLUSH);
    assign sts.sum_done = rd_live_reg && rd_tag_reg;
    assign sts.ar_done  = !busy_reg;
    assign sts.ren1_go  = ren1_go;
    assign sts.ren2_go  = ren2_go;
    assign sts.out_free = out_free;
    assign sts.mark     = mark;
    assign sts.coded    = total_reg > TOTAL_RST;

    assign out_valid      = out_valid_reg;
    assign out_lead_bit   = out_lead_reg;
    assign out_run_length = out_run_reg;
    assign out_last       = out_last_reg;

    // memory port: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.upd)
            mem[sym_reg] <= cnt_reg + CW'(1);
        rd_data_reg <= mem[idx_reg[IW-1:0]];
        rd_vld_reg  <= vbits_reg[idx_reg[IW-1:0]];
    end

    // payload and arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sym_reg <= sym_sat;
            cum_reg <= '0;
        end
        else if (rd_live_reg)
        begin
            if (rd_tag_reg)
                cnt_reg <= rd_val;
            else
                cum_reg <= cum_reg + rd_val;
        end

        if (cmd.ar_start)
        begin
            a_reg   <= cmd.ar_sel ? (cum_reg + cnt_reg) : cum_reg;
            rng_reg <= range_w;
            acc_reg <= '0;
            rem_reg <= '0;
            if (cmd.ar_sel)
                nlow_reg <= low_reg + q_reg[SB-1:0];
        end
        else if (busy_reg)
        begin
            if (step_reg > SCW'(PW))
            begin
                // shift-add multiply, range msb first
                acc_reg <= (acc_reg << 1) + (rng_reg[RW-1] ? PW'(a_reg) : PW'(0));
                rng_reg <= rng_reg << 1;
            end
            else
            begin
                // restoring divide by total
                acc_reg <= acc_reg << 1;
                rem_reg <= div_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
                q_reg   <= {q_reg[RW-2:0], div_ge};
            end
        end

        if (emit_any)
        begin
            out_lead_reg <= cmd.ren1_step ? low_reg[SB-1] : 1'b1;
            out_run_reg  <= cmd.ren1_step ? pend_reg : '0;
            out_last_reg <= cmd.ren1_step ? ren1_last : 1'b1;
        end
    end

    // control and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbits_reg     <= '0;
            idx_reg       <= '0;
            rd_live_reg   <= 1'b0;
            rd_tag_reg    <= 1'b0;
            step_reg      <= '0;
            busy_reg      <= 1'b0;
            low_reg       <= '0;
            high_reg      <= '1;
            pend_reg      <= '0;
            total_reg     <= TOTAL_RST;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                idx_reg <= '0;
            else if (issue)
                idx_reg <= idx_reg + (IW + 1)'(1);
            rd_live_reg <= issue;
            rd_tag_reg  <= issue && (idx_reg[IW-1:0] == sym_reg);

            if (cmd.ar_start)
            begin
                step_reg <= SCW'(RW + PW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - SCW'(1);
                if (step_reg == SCW'(1))
                    busy_reg <= 1'b0;
            end

            if (cmd.ren_start)
                i_reg <= '0;
            else if (cmd.ren1_step || cmd.ren2_step)
                i_reg <= i_reg + IBW'(1);

            if (cmd.clear_model)
            begin
                vbits_reg <= '0;
                total_reg <= TOTAL_RST;
                low_reg   <= '0;
                high_reg  <= '1;
                pend_reg  <= '0;
            end
            else if (cmd.upd)
            begin
                vbits_reg[sym_reg] <= 1'b1;
                total_reg <= total_reg + CW'(1);
                low_reg   <= nlow_reg;
                high_reg  <= low_reg + q_reg[SB-1:0] - SB'(1);
            end
            else if (cmd.ren1_step)
            begin
                pend_reg <= '0;
                low_reg  <= {low_reg[SB-2:0], 1'b0};
                high_reg <= {high_reg[SB-2:0], 1'b1};
            end
            else if (cmd.ren2_step)
            begin
                if (pend_reg != '1)
                    pend_reg <= pend_reg + PEND_W'(1);
                low_reg  <= {1'b0, low_reg[SB-3:0], 1'b0};
                high_reg <= {1'b1, high_reg[SB-3:0], 1'b1};
            end

            if (emit_any)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ar_start |-> !busy_reg)
        else $error("arithmetic start while unit busy");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit_any |-> out_free)
        else $error("result written over an untaken transaction");

    a_ren_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ren1_step |-> ren1_go)
        else $error("bit emitted without matching top bits");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_model |=> (total_reg == TOTAL_RST && pend_reg == '0 && vbits_reg == '0))
        else $error("model clear incomplete");

endmodule

`default_nettype wire
